// File: rtl/calendar_clock_with_decimal_digits_top_defines.svh
// assertion macros shared by the calendar clock rtl
// expects clk and rst in the scope of each use
`ifndef CALENDAR_CLOCK_WITH_DECIMAL_DIGITS_TOP_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_DECIMAL_DIGITS_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define CCDD_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define CCDD_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCDD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ccdd_pkg.sv
// types, constants and helper functions of the calendar clock
// no dependencies
`timescale 1ns / 1ps
package ccdd_pkg;

  localparam int YearW  = 16;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int TenthW = 4;
  localparam int BcdW   = 20;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } command_t;

  typedef struct packed {
    command_t            command;
    logic [YearW-1:0]    load_year;
    logic [MonthW-1:0]   load_month;
    logic [DayW-1:0]     load_day;
    logic [HourW-1:0]    load_hours;
    logic [MinW-1:0]     load_minutes;
    logic [SecW-1:0]     load_seconds;
  } cmd_t;

  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hours;
    logic [MinW-1:0]     minutes;
    logic [SecW-1:0]     seconds;
    logic [TenthW-1:0]   tenths;
    logic                running;
    logic [63:0]         date_ascii;
    logic [47:0]         time_ascii;
  } rsp_t;

  // calendar state as held by the counters
  typedef struct packed {
    logic [YearW-1:0]    year;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HourW-1:0]    hours;
    logic [MinW-1:0]     minutes;
    logic [SecW-1:0]     seconds;
    logic [TenthW-1:0]   tenths;
    logic                running;
  } clock_t;

  // days in month plus one, february for unused month codes
  function automatic logic [5:0] day_limit(logic [MonthW-1:0] m, logic [YearW-1:0] y);
    logic [5:0] lim;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 6'd32;
      4'd4, 4'd6, 4'd9, 4'd11:                    lim = 6'd31;
      default:                                    lim = (y[1:0] != 2'b00) ? 6'd29 : 6'd30;
    endcase
    return lim;
  endfunction

  // eight shift-add-3 steps, msb of bits first
  function automatic logic [BcdW-1:0] dabble8(logic [BcdW-1:0] bcd, logic [7:0] bits);
    logic [BcdW-1:0] acc;
    int k;
    int d;
    acc = bcd;
    for (k = 7; k >= 0; k--) begin
      for (d = 0; d < BcdW / 4; d++) begin
        if (acc[4*d +: 4] >= 4'd5) begin
          acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BcdW-2:0], bits[k]};
    end
    return acc;
  endfunction

  function automatic logic [7:0] ascii_digit(logic [3:0] d);
    return ASCII_ZERO | {4'b0000, d};
  endfunction

  // values below 64, so always two digits
  function automatic logic [15:0] two_digits(logic [5:0] v);
    logic [BcdW-1:0] bcd;
    bcd = dabble8('0, {2'b00, v});
    return {ascii_digit(bcd[7:4]), ascii_digit(bcd[3:0])};
  endfunction

endpackage

// File: rtl/ccdd_cmd_if.sv
// command channel: valid, ready and one command beat
// depends on ccdd_pkg
`timescale 1ns / 1ps
interface ccdd_cmd_if;
  import ccdd_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/ccdd_rsp_if.sv
// response channel: valid, ready and one result beat
// depends on ccdd_pkg
`timescale 1ns / 1ps
interface ccdd_rsp_if;
  import ccdd_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/ccdd_count.sv
// calendar counters: load, tenth tick and carry chain into the year
// depends on ccdd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "calendar_clock_with_decimal_digits_top_defines.svh"
module ccdd_count (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  ccdd_pkg::cmd_t  cmd_data,
  output ccdd_pkg::clock_t upd
);
  import ccdd_pkg::*;

  clock_t      cur;
  clock_t      cur_next;
  logic [4:0]  tenth_inc;
  logic [6:0]  sec_inc;
  logic [6:0]  sec_sub;
  logic [5:0]  sec_wrap;
  logic [6:0]  min_inc;
  logic [6:0]  min_sub;
  logic [5:0]  min_wrap;
  logic [5:0]  hour_inc;
  logic [5:0]  hour_sub;
  logic [4:0]  hour_wrap;
  logic [5:0]  day_inc;
  logic [5:0]  day_lim;
  logic [5:0]  day_sub;
  logic [4:0]  day_wrap;
  logic [4:0]  mon_inc;
  logic [4:0]  mon_sub;
  logic [3:0]  mon_wrap;

  always_comb begin
    tenth_inc = {1'b0, cur.tenths} + 5'd1;
    sec_inc   = {1'b0, cur.seconds} + 7'd1;
    sec_sub   = sec_inc - 7'd60;
    sec_wrap  = (sec_inc >= 7'd60) ? sec_sub[5:0] : sec_inc[5:0];
    min_inc   = {1'b0, cur.minutes} + 7'd1;
    min_sub   = min_inc - 7'd60;
    min_wrap  = (min_inc >= 7'd60) ? min_sub[5:0] : min_inc[5:0];
    hour_inc  = {1'b0, cur.hours} + 6'd1;
    hour_sub  = hour_inc - 6'd24;
    hour_wrap = (hour_inc >= 6'd24) ? hour_sub[4:0] : hour_inc[4:0];
    day_inc   = {1'b0, cur.day} + 6'd1;
    day_lim   = day_limit(cur.month, cur.year);
    day_sub   = day_inc - day_lim;
    day_wrap  = (day_inc >= day_lim) ? day_sub[4:0] : day_inc[4:0];
    mon_inc   = {1'b0, cur.month} + 5'd1;
    mon_sub   = mon_inc - 5'd13;
    mon_wrap  = (mon_inc >= 5'd13) ? mon_sub[3:0] : mon_inc[3:0];
  end

  always_comb begin
    cur_next = cur;
    if (cmd_data.command == CMD_LOAD) begin
      cur_next.year    = cmd_data.load_year;
      cur_next.month   = cmd_data.load_month;
      cur_next.day     = cmd_data.load_day;
      cur_next.hours   = cmd_data.load_hours;
      cur_next.minutes = cmd_data.load_minutes;
      cur_next.seconds = cmd_data.load_seconds;
      cur_next.running = 1'b1;
    end else if (cur.running) begin
      if (tenth_inc == 5'd10) begin
        cur_next.tenths  = '0;
        cur_next.seconds = sec_wrap;
        if (sec_wrap == '0) begin
          cur_next.minutes = min_wrap;
          if (min_wrap == '0) begin
            cur_next.hours = hour_wrap;
            if (hour_wrap == '0) begin
              if (day_wrap != '0) begin
                cur_next.day = day_wrap;
              end else begin
                cur_next.day = 5'd1;
                if (mon_wrap != '0) begin
                  cur_next.month = mon_wrap;
                end else begin
                  cur_next.month = 4'd1;
                  cur_next.year  = cur.year + 16'd1;
                end
              end
            end
          end
        end
      end else begin
        cur_next.tenths = tenth_inc[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (take) begin
      cur <= cur_next;
    end
  end

  assign upd = cur_next;

  `CCDD_NEXT(a_load_runs, take && cmd_data.command == CMD_LOAD, cur.running, "load did not start counting")
  `CCDD_NEXT(a_idle_tick, take && !cur.running && cmd_data.command == CMD_TICK, $stable(cur), "tick before load changed state")
  `CCDD_HOLDS(a_tenth_range, cur.tenths < 4'd10, "tenths out of range")

endmodule

// File: rtl/ccdd_digits.sv
// digit pipeline: year binary to bcd in two halves, ascii strings, result register
// depends on ccdd_pkg, ccdd_rsp_if and the assertion macro header
`timescale 1ns / 1ps
`include "calendar_clock_with_decimal_digits_top_defines.svh"
module ccdd_digits (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  ccdd_pkg::clock_t upd,
  output logic             room,
  ccdd_rsp_if.source       rsp
);
  import ccdd_pkg::*;

  logic            v1;
  clock_t          s1;
  logic            v2;
  clock_t          s2;
  logic [BcdW-1:0] year_part;
  logic            out_valid;
  rsp_t            out_data;
  rsp_t            out_data_next;
  logic [BcdW-1:0] year_bcd;
  logic            out_adv;
  logic            r2;

  assign out_adv = !out_valid || rsp.ready;
  assign r2      = !v2 || out_adv;
  assign room    = !v1 || r2;

  always_comb begin
    year_bcd = dabble8(year_part, s2.year[7:0]);
    out_data_next.year    = s2.year;
    out_data_next.month   = s2.month;
    out_data_next.day     = s2.day;
    out_data_next.hours   = s2.hours;
    out_data_next.minutes = s2.minutes;
    out_data_next.seconds = s2.seconds;
    out_data_next.tenths  = s2.tenths;
    out_data_next.running = s2.running;
    out_data_next.date_ascii = '0;
    out_data_next.time_ascii = '0;
    if (s2.running) begin
      out_data_next.date_ascii = {ascii_digit(year_bcd[15:12]), ascii_digit(year_bcd[11:8]),
                                  ascii_digit(year_bcd[7:4]), ascii_digit(year_bcd[3:0]),
                                  two_digits({2'b00, s2.month}), two_digits({1'b0, s2.day})};
      out_data_next.time_ascii = {two_digits({1'b0, s2.hours}), two_digits(s2.minutes),
                                  two_digits(s2.seconds)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (room) begin
        v1 <= take;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (out_adv) begin
        out_valid <= v2;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (room) begin
      s1 <= upd;
    end
    if (r2) begin
      s2        <= s1;
      year_part <= dabble8('0, s1.year[15:8]);
    end
    if (out_adv) begin
      out_data <= out_data_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `CCDD_IMPLIES(a_blank_strings, out_valid && !out_data.running, out_data.date_ascii == '0 && out_data.time_ascii == '0, "digits shown before load")
  `CCDD_IMPLIES(a_stall_full, !room, v1 && v2 && out_valid && !rsp.ready, "input stalled with a free stage")
  `CCDD_NEXT(a_out_hold, out_valid && !rsp.ready, out_valid && $stable(out_data), "beat dropped")

endmodule

// File: rtl/calendar_clock_with_decimal_digits_top.sv
// calendar clock: a command beat passes through the s1, s2 and output registers to the result beat
// throughput one beat per cycle while rsp.ready allows; the counters update in the accept cycle
// and the year conversion runs over two registered stages
// reset (rst, synchronous) clears all counters, stops counting, empties the pipe
// depends on ccdd_pkg, ccdd_cmd_if, ccdd_rsp_if, ccdd_count, ccdd_digits
`timescale 1ns / 1ps
module calendar_clock_with_decimal_digits_top (
  input  logic       clk,
  input  logic       rst,
  ccdd_cmd_if.sink   cmd,
  ccdd_rsp_if.source rsp
);
  import ccdd_pkg::*;

  logic   room;
  logic   take;
  clock_t upd;

  assign cmd.ready = room;
  assign take      = cmd.valid && room;

  ccdd_count u_count (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd_data (cmd.data),
    .upd      (upd)
  );

  ccdd_digits u_digits (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .upd  (upd),
    .room (room),
    .rsp  (rsp)
  );

endmodule

// File: tb/tb_calendar_clock_with_decimal_digits_top.sv
// self-checking testbench of the calendar clock: load and tick beats in, readings out
// predicts every reading, compares field by field; uses ccdd_pkg and both channel interfaces
`timescale 1ns / 1ps
module tb_calendar_clock_with_decimal_digits_top;
  import ccdd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;

  ccdd_cmd_if cmd_if();
  ccdd_rsp_if rsp_if();

  calendar_clock_with_decimal_digits_top i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  clock_t cal_state = '0;
  rsp_t   expected_readings[$];
  int     error_count = 0;
  int     readings_checked = 0;
  int     loads_sent = 0;
  int     ticks_sent = 0;
  int     cycle_count = 0;
  bit     idle_enabled = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int month_length(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      default:               return (y % 4 != 0) ? 28 : 29;
    endcase
  endfunction

  function automatic logic [7:0] ascii_of(int d);
    return ASCII_ZERO + 8'(d);
  endfunction

  function automatic logic [15:0] ascii_pair(int v);
    return {ascii_of((v % 100) / 10), ascii_of(v % 10)};
  endfunction

  function automatic void step_second();
    int d;
    int m;
    cal_state.seconds = SecW'((int'(cal_state.seconds) + 1) % 60);
    if (cal_state.seconds != 0) return;
    cal_state.minutes = MinW'((int'(cal_state.minutes) + 1) % 60);
    if (cal_state.minutes != 0) return;
    cal_state.hours = HourW'((int'(cal_state.hours) + 1) % 24);
    if (cal_state.hours != 0) return;
    d = (int'(cal_state.day) + 1) %
        (month_length(int'(cal_state.month), int'(cal_state.year)) + 1);
    if (d != 0) begin
      cal_state.day = DayW'(d);
      return;
    end
    cal_state.day = DayW'(1);
    m = (int'(cal_state.month) + 1) % 13;
    if (m != 0) begin
      cal_state.month = MonthW'(m);
      return;
    end
    cal_state.month = MonthW'(1);
    cal_state.year = cal_state.year + 1'b1;
  endfunction

  function automatic rsp_t predict_reading(cmd_t c);
    rsp_t r;
    int y;
    if (c.command == CMD_LOAD) begin
      cal_state.year    = c.load_year;
      cal_state.month   = c.load_month;
      cal_state.day     = c.load_day;
      cal_state.hours   = c.load_hours;
      cal_state.minutes = c.load_minutes;
      cal_state.seconds = c.load_seconds;
      cal_state.running = 1'b1;
    end else if (cal_state.running) begin
      cal_state.tenths = TenthW'((int'(cal_state.tenths) + 1) % 10);
      if (cal_state.tenths == 0) step_second();
    end
    r = '0;
    r.year    = cal_state.year;
    r.month   = cal_state.month;
    r.day     = cal_state.day;
    r.hours   = cal_state.hours;
    r.minutes = cal_state.minutes;
    r.seconds = cal_state.seconds;
    r.tenths  = cal_state.tenths;
    r.running = cal_state.running;
    if (cal_state.running) begin
      y = int'(cal_state.year) % 10000;
      r.date_ascii = {ascii_of(y / 1000), ascii_of((y / 100) % 10), ascii_pair(y % 100),
                      ascii_pair(int'(cal_state.month)), ascii_pair(int'(cal_state.day))};
      r.time_ascii = {ascii_pair(int'(cal_state.hours)), ascii_pair(int'(cal_state.minutes)),
                      ascii_pair(int'(cal_state.seconds))};
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // predict at each command beat, check each result beat against the oldest reading
  always @(posedge clk) begin : watch_beats
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready) begin
        expected_readings.push_back(predict_reading(cmd_if.data));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_readings.size() == 0) begin
          error_count++;
          $display("%0t: result beat with none expected, actual %h", $time, got);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          compare_field("year", want.year, got.year);
          compare_field("month", want.month, got.month);
          compare_field("day", want.day, got.day);
          compare_field("hours", want.hours, got.hours);
          compare_field("minutes", want.minutes, got.minutes);
          compare_field("seconds", want.seconds, got.seconds);
          compare_field("tenths", want.tenths, got.tenths);
          compare_field("running", want.running, got.running);
          compare_field("date_ascii", want.date_ascii, got.date_ascii);
          compare_field("time_ascii", want.time_ascii, got.time_ascii);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idle_enabled) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(cmd_t c);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    do @(posedge clk); while (!cmd_if.ready);
    if (c.command == CMD_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  function automatic cmd_t random_beat();
    cmd_t c;
    c.command      = command_t'($urandom_range(0, 1));
    c.load_year    = YearW'($urandom);
    c.load_month   = MonthW'($urandom);
    c.load_day     = DayW'($urandom);
    c.load_hours   = HourW'($urandom);
    c.load_minutes = MinW'($urandom);
    c.load_seconds = SecW'($urandom);
    return c;
  endfunction

  function automatic cmd_t make_load(int y, int mo, int d, int h, int mi, int s);
    cmd_t c;
    c.command      = CMD_LOAD;
    c.load_year    = YearW'(y);
    c.load_month   = MonthW'(mo);
    c.load_day     = DayW'(d);
    c.load_hours   = HourW'(h);
    c.load_minutes = MinW'(mi);
    c.load_seconds = SecW'(s);
    return c;
  endfunction

  // mostly the top of the range so that carries ripple, sometimes any bit pattern
  function automatic int biased_field(int lo, int hi, int width);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return hi;
    if (r == 5) return $urandom_range(0, (1 << width) - 1);
    return $urandom_range(lo, hi);
  endfunction

  function automatic cmd_t calendar_load();
    int y;
    int mo;
    int d;
    case ($urandom_range(0, 9))
      0:       y = 65535;
      1:       y = 0;
      2:       y = 9999;
      3:       y = 4 * $urandom_range(0, 16383);
      default: y = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 9))
      0, 1:    mo = $urandom_range(0, 15);
      2, 3:    mo = 12;
      4, 5:    mo = 2;
      default: mo = $urandom_range(1, 12);
    endcase
    case ($urandom_range(0, 9))
      0:       d = $urandom_range(0, 31);
      1, 2, 3: d = $urandom_range(28, 31);
      4:       d = month_length(mo, y);
      default: d = $urandom_range(1, 31);
    endcase
    return make_load(y, mo, d, biased_field(0, 23, HourW), biased_field(0, 59, MinW),
                     biased_field(0, 59, SecW));
  endfunction

  task automatic send_ticks(int n);
    cmd_t c;
    repeat (n) begin
      c = random_beat();
      c.command = CMD_TICK;
      send_beat(c);
    end
  endtask

  task automatic test_ticks_before_load();
    cmd_t c;
    cmd_t ones;
    c = '0;
    c.command = CMD_TICK;
    ones = ~c;
    ones.command = CMD_TICK;
    send_beat(c);
    send_beat(ones);
    send_ticks(1);
  endtask

  task automatic test_load_extremes();
    send_beat(make_load(65535, 15, 31, 31, 63, 63));
    send_beat(make_load(0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_year_wrap();
    send_beat(make_load(65535, 12, 31, 23, 59, 59));
    send_ticks(10);
  endtask

  task automatic test_leap_day();
    send_beat(make_load(2024, 2, 28, 23, 59, 59));
    send_ticks(10);
  endtask

  task automatic test_random_sequences(int n_items);
    int start;
    start = loads_sent + ticks_sent;
    while (loads_sent + ticks_sent - start < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_beat(calendar_load());
        send_ticks($urandom_range(1, 30));
      end else begin
        repeat ($urandom_range(1, 8)) send_beat(random_beat());
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    test_random_sequences(200);
  endtask

  initial begin
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ticks_before_load();
    test_load_extremes();
    test_year_wrap();
    test_leap_day();
    test_random_sequences(1500);
    test_back_to_back();

    cmd_if.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d loads and %0d ticks, compared %0d readings",
             loads_sent, ticks_sent, readings_checked);
    $display("ticks before load, out-of-range loads, leap days, year wrap, random carries");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
